FILE: rtl/path_occlusion_check_unit_defines.svh
// Assertion macros shared by the path occlusion check RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef PATH_OCCLUSION_CHECK_UNIT_DEFINES_SVH
`define PATH_OCCLUSION_CHECK_UNIT_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define POC_ASSERT_IMP(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define POC_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/poc_pkg.sv
// Shared types, widths and codes for the path occlusion check unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package poc_pkg;
    localparam int OBSTACLE_SLOTS = 32;
    localparam int SLOT_W = (OBSTACLE_SLOTS > 1) ? $clog2(OBSTACLE_SLOTS) : 1;
    localparam int CNT_W = $clog2(OBSTACLE_SLOTS + 1);
    localparam logic [15:0] MAX_LENGTH_RESET = 16'd5120;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_TOO_FAR = 2'd1;
    localparam logic [1:0] ST_BLOCKED = 2'd2;
    localparam logic [1:0] ST_SAME = 2'd3;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Classified work item passed from front to back.
    typedef struct packed {
        logic        is_load;
        logic [4:0]  slot;
        logic signed [23:0] left;
        logic signed [23:0] top;
        logic [22:0] width;
        logic [22:0] height;
        logic        used;
        logic signed [23:0] sx;
        logic signed [23:0] sy;
        logic signed [24:0] dx;
        logic signed [24:0] dy;
        logic [24:0] len;
        logic        too_far;
    } work_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] reach_length;
        logic signed [17:0] step_x;
        logic signed [17:0] step_y;
    } result_t;
endpackage

FILE: rtl/poc_front.sv
// Front end: accepts input beats, forms deltas and length, compares to limit.
// Depends on poc_pkg.
`timescale 1ns / 1ps
module poc_front
    import poc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [199:0] in_data,
    input  logic        in_cmd,
    input  logic [15:0] max_length,
    output logic        q_valid,
    input  logic        q_ready,
    output work_t       q_item
);
    // Two-entry queue toward the back end.
    work_t       mem_reg [2];
    logic        wp_reg, rp_reg;
    logic [1:0]  cnt_reg;
    work_t       item;
    logic signed [24:0] dx, dy;
    logic [24:0] ax, ay;
    logic        push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign push = in_valid && in_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop = q_valid && q_ready;
    assign q_item = mem_reg[rp_reg];

    always_comb
    begin
        dx = $signed({in_data[171], in_data[171:148]}) - $signed({in_data[123], in_data[123:100]});
        dy = $signed({in_data[195], in_data[195:172]}) - $signed({in_data[147], in_data[147:124]});
        ax = dx[24] ? 25'(-dx) : 25'(dx);
        ay = dy[24] ? 25'(-dy) : 25'(dy);
        item.is_load = (in_cmd == CMD_LOAD);
        item.slot = in_data[4:0];
        item.left = in_data[28:5];
        item.top = in_data[52:29];
        item.width = in_data[75:53];
        item.height = in_data[98:76];
        item.used = in_data[99];
        item.sx = in_data[123:100];
        item.sy = in_data[147:124];
        item.dx = dx;
        item.dy = dy;
        item.len = (ax > ay) ? ax : ay;
        item.too_far = (item.len > {9'd0, max_length});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wp_reg] <= item;
    end
endmodule

FILE: rtl/poc_back.sv
// Back end: obstacle table, step divider and point walk over all slots.
// Depends on poc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "path_occlusion_check_unit_defines.svh"
module poc_back
    import poc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    q_valid,
    output logic    q_ready,
    input  work_t   q_item,
    output logic    res_valid,
    input  logic    res_ready,
    output result_t res
);
    typedef enum logic [2:0] {S_IDLE, S_DIV, S_RD, S_CMP, S_DONE} state_t;

    state_t state_reg;
    logic [OBSTACLE_SLOTS-1:0] active_reg;
    logic signed [23:0] ml [OBSTACLE_SLOTS];
    logic signed [23:0] mt [OBSTACLE_SLOTS];
    logic [22:0] mw [OBSTACLE_SLOTS];
    logic [22:0] mh [OBSTACLE_SLOTS];

    work_t   w_reg;
    logic [4:0]  bit_reg;
    logic [40:0] remx_reg, remy_reg;
    logic [16:0] qx_reg, qy_reg;
    logic signed [33:0] px_reg, py_reg;
    logic signed [17:0] stx_reg, sty_reg;
    logic [16:0] pts_reg;
    logic [CNT_W-1:0] s_reg;
    logic signed [23:0] rl_reg, rt_reg;
    logic [22:0] rw_reg, rh_reg;
    logic        ract_reg;
    logic        hit_reg;
    result_t     res_reg;
    logic        res_valid_reg;

    logic signed [33:0] l34, r34, t34, d34;
    logic        pt_hit;
    result_t     done_res;

    assign q_ready = (state_reg == S_IDLE);
    assign res_valid = res_valid_reg;
    assign res = res_reg;

    always_comb
    begin
        l34 = {{2{rl_reg[23]}}, rl_reg, 8'd0};
        t34 = {{2{rt_reg[23]}}, rt_reg, 8'd0};
        r34 = l34 + $signed({3'd0, rw_reg, 8'd0});
        d34 = t34 + $signed({3'd0, rh_reg, 8'd0});
        pt_hit = ract_reg && px_reg >= l34 && px_reg <= r34 && py_reg >= t34 && py_reg <= d34;
    end

    always_comb
    begin
        done_res = '0;
        if (w_reg.too_far) done_res.status = ST_TOO_FAR;
        else if (hit_reg) done_res.status = ST_BLOCKED;
        else if (w_reg.len == 25'd0) done_res.status = ST_SAME;
        else
        begin
            done_res.status = ST_OK;
            done_res.reach_length = w_reg.len[15:0];
            done_res.step_x = stx_reg;
            done_res.step_y = sty_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && q_valid && q_item.is_load
            && 32'(q_item.slot) < OBSTACLE_SLOTS)
        begin
            ml[q_item.slot[SLOT_W-1:0]] <= q_item.left;
            mt[q_item.slot[SLOT_W-1:0]] <= q_item.top;
            mw[q_item.slot[SLOT_W-1:0]] <= q_item.width;
            mh[q_item.slot[SLOT_W-1:0]] <= q_item.height;
        end
        if (state_reg == S_RD)
        begin
            rl_reg <= ml[s_reg[SLOT_W-1:0]];
            rt_reg <= mt[s_reg[SLOT_W-1:0]];
            rw_reg <= mw[s_reg[SLOT_W-1:0]];
            rh_reg <= mh[s_reg[SLOT_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            active_reg <= '0;
            res_valid_reg <= 1'b0;
            hit_reg <= 1'b0;
        end
        else
        begin
            if (res_valid_reg && res_ready && state_reg != S_DONE) res_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        w_reg <= q_item;
                        if (q_item.is_load)
                        begin
                            if (32'(q_item.slot) < OBSTACLE_SLOTS)
                                active_reg[q_item.slot[SLOT_W-1:0]] <= q_item.used;
                        end
                        else if (q_item.too_far)
                        begin
                            hit_reg <= 1'b0;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            // magnitude << 16, divided by len one bit a cycle
                            remx_reg <= {(q_item.dx[24] ? 25'(-q_item.dx) : 25'(q_item.dx)),
                                         16'd0};
                            remy_reg <= {(q_item.dy[24] ? 25'(-q_item.dy) : 25'(q_item.dy)),
                                         16'd0};
                            qx_reg <= '0;
                            qy_reg <= '0;
                            bit_reg <= 5'd16;
                            hit_reg <= 1'b0;
                            state_reg <= S_DIV;
                        end
                    end
                end
                S_DIV:
                begin
                    // restoring divide: rem holds dividend, compare shifted len
                    if (w_reg.len == 25'd0)
                    begin
                        stx_reg <= '0;
                        sty_reg <= '0;
                    end
                    if ({remx_reg} >= ({16'd0, w_reg.len} << bit_reg) && w_reg.len != 0)
                    begin
                        remx_reg <= remx_reg - ({16'd0, w_reg.len} << bit_reg);
                        qx_reg[bit_reg] <= 1'b1;
                    end
                    if ({remy_reg} >= ({16'd0, w_reg.len} << bit_reg) && w_reg.len != 0)
                    begin
                        remy_reg <= remy_reg - ({16'd0, w_reg.len} << bit_reg);
                        qy_reg[bit_reg] <= 1'b1;
                    end
                    if (bit_reg == 5'd0)
                        state_reg <= S_RD;
                    else
                        bit_reg <= bit_reg - 5'd1;
                    px_reg <= {{2{w_reg.sx[23]}}, w_reg.sx, 8'd0};
                    py_reg <= {{2{w_reg.sy[23]}}, w_reg.sy, 8'd0};
                    pts_reg <= {1'b0, w_reg.len[23:8]} + 17'd1;
                    s_reg <= '0;
                end
                S_RD:
                begin
                    if (s_reg == CNT_W'(0) && pts_reg == {1'b0, w_reg.len[23:8]} + 17'd1)
                    begin
                        stx_reg <= w_reg.dx[24] ? -$signed({1'b0, qx_reg}) : $signed({1'b0, qx_reg});
                        sty_reg <= w_reg.dy[24] ? -$signed({1'b0, qy_reg}) : $signed({1'b0, qy_reg});
                    end
                    ract_reg <= active_reg[s_reg[SLOT_W-1:0]];
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if (pt_hit)
                    begin
                        hit_reg <= 1'b1;
                        state_reg <= S_DONE;
                    end
                    else if (s_reg == CNT_W'(OBSTACLE_SLOTS - 1))
                    begin
                        s_reg <= '0;
                        px_reg <= px_reg + 34'(stx_reg);
                        py_reg <= py_reg + 34'(sty_reg);
                        pts_reg <= pts_reg - 17'd1;
                        state_reg <= (pts_reg == 17'd1) ? S_DONE : S_RD;
                    end
                    else
                    begin
                        s_reg <= s_reg + CNT_W'(1);
                        state_reg <= S_RD;
                    end
                end
                S_DONE:
                begin
                    if (!res_valid_reg || res_ready)
                    begin
                        res_valid_reg <= 1'b1;
                        res_reg <= done_res;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `POC_ASSERT_IMP(a_ready_idle, clk, rst_n, q_ready, state_reg == S_IDLE, "ready outside idle")
    `POC_ASSERT_NEXT(a_done_out, clk, rst_n, state_reg == S_DONE && (!res_valid_reg || res_ready), res_valid_reg, "result lost")
    `POC_ASSERT_IMP(a_ok_len, clk, rst_n, res_valid_reg && res_reg.status != ST_OK, res_reg.reach_length == 16'd0, "length not cleared")
endmodule

FILE: rtl/path_occlusion_check_unit.sv
// Top level of the path occlusion check unit: front, queue and back end.
// Depends on poc_pkg, poc_front and poc_back.
//  channel | dir | content
//  s_axis  | in  | tdata: slot,box_left,box_top,box_width,box_height,box_used,
//          |     |   start_x,start_y,target_x,target_y; tuser: command
//  m_axis  | out | tdata: reach_length,step_x,step_y; tuser: status
//  cfg     | in  | max_length write
// A load passes the front queue and is written into the table in idle; a too_far
// item goes from idle to S_DONE. Otherwise the deltas are divided by the length,
// then floor(L/256)+1 points are walked over all slots, ending early on a hit.
// The per-slot compare loop over the obstacle table sets the rate.
// Reset clears the active flags, the limit to 5120 and all handshake state.
// The output holds until taken; the back end stalls in S_DONE meanwhile.
`timescale 1ns / 1ps
module path_occlusion_check_unit
    import poc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [199:0] s_axis_tdata,  // slot,left,top,width,height,used,sx,sy,tx,ty
    input  logic         s_axis_tuser,  // command
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [55:0]  m_axis_tdata,  // reach_length, step_x, step_y
    output logic [1:0]   m_axis_tuser,  // status
    input  logic         cfg_we,
    input  logic [15:0]  cfg_wdata
);
    logic [15:0] max_length_reg;
    logic        q_valid, q_ready;
    work_t       q_item;
    result_t     res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_length_reg <= MAX_LENGTH_RESET;
        else if (cfg_we)
            max_length_reg <= cfg_wdata;
    end

    poc_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_data(s_axis_tdata), .in_cmd(s_axis_tuser), .max_length(max_length_reg),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    poc_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
        .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(res)
    );

    assign m_axis_tdata = {4'd0, res.step_y, res.step_x, res.reach_length};
    assign m_axis_tuser = res.status;
endmodule
